>>> design/b2dt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2dt_pkg: shared types and constants for the binary to decimal text block
// Microcode word layout, datapath control bundle and place power table.
// ----------------------------------------------------------------------------
package b2dt_pkg;

  localparam int unsigned ValueWidth = 24;
  localparam int unsigned DigitWidth = 5;
  localparam int unsigned PcWidth    = 5;

  localparam logic [6:0] CharZero = 7'h30;

  // Place selects, millions down to tens
  localparam logic [2:0] PlaceMil  = 3'd0;
  localparam logic [2:0] PlaceHk   = 3'd1;
  localparam logic [2:0] PlaceTk   = 3'd2;
  localparam logic [2:0] PlaceK    = 3'd3;
  localparam logic [2:0] PlaceHund = 3'd4;
  localparam logic [2:0] PlaceTen  = 3'd5;

  typedef enum logic [1:0] {
    OP_TRIAL,
    OP_EMIT,
    OP_EMIT_LAST
  } op_e;

  typedef struct packed {
    op_e                op;
    logic [2:0]         place;
    logic [2:0]         shift;
    logic [PcWidth-1:0] target;
  } ucode_t;

  typedef struct packed {
    logic       load;
    logic       trial;
    logic       clr_digit;
    logic [2:0] place;
    logic [2:0] shift;
  } dp_ctl_t;

  function automatic logic [ValueWidth-1:0] place_pow(input logic [2:0] sel);
    logic [ValueWidth-1:0] pw;
    case (sel)
      PlaceMil:  pw = 24'd1000000;
      PlaceHk:   pw = 24'd100000;
      PlaceTk:   pw = 24'd10000;
      PlaceK:    pw = 24'd1000;
      PlaceHund: pw = 24'd100;
      PlaceTen:  pw = 24'd10;
      default:   pw = 24'd10;
    endcase
    return pw;
  endfunction

  function automatic ucode_t uc_trial(input logic [2:0] place, input logic [2:0] shift,
                                      input logic [PcWidth-1:0] target);
    ucode_t w;
    w.op     = OP_TRIAL;
    w.place  = place;
    w.shift  = shift;
    w.target = target;
    return w;
  endfunction

  function automatic ucode_t uc_emit(input op_e op);
    ucode_t w;
    w.op     = op;
    w.place  = PlaceMil;
    w.shift  = 3'd0;
    w.target = '0;
    return w;
  endfunction

endpackage

>>> design/binary_to_decimal_text.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_to_decimal_text: formats a 1 to 3 byte unsigned value as decimal text
// Emits one column / ASCII character write per written place, ones last.
// ----------------------------------------------------------------------------
// A transaction on the input loads the value; a microprogram of 32 steps then
// runs one step per clock, except while an emit step waits on a full output
// register, on a single shared compare-subtract unit. Each place from millions
// to tens spends up to four trial steps (five for millions) and one emit step,
// and a trial step jumps to the emit once the remainder is below the place
// power. The next item is taken as soon as the ones write sits in the output
// register, even if it has not yet been taken downstream.
module binary_to_decimal_text (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] first_byte_i,
  input  logic [7:0] second_byte_i,
  input  logic [7:0] third_byte_i,
  input  logic [3:0] byte_count_i,
  input  logic       leading_zeros_i,
  input  logic       left_align_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] column_o,
  output logic [6:0] char_code_o,
  output logic       last_o
);
  import b2dt_pkg::*;

  logic               busy_q, busy_d;
  logic [PcWidth-1:0] pc_q, pc_d;
  logic               past_q, past_d;
  logic [2:0]         col_q, col_d;
  logic               zfill_q, zfill_d;
  logic               lalign_q, lalign_d;
  logic               out_valid_q, out_valid_d;
  logic [2:0]         column_q, column_d;
  logic [6:0]         char_q, char_d;
  logic               last_q, last_d;

  ucode_t                word;
  dp_ctl_t               ctl;
  logic [DigitWidth-1:0] digit;
  logic [3:0]            ones;
  logic                  below;
  logic                  accept;
  logic                  out_free;
  logic                  nonzero;
  logic                  write;

  b2dt_ucode_rom u_rom (
    .addr_i (pc_q),
    .word_o (word)
  );

  b2dt_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl),
    .first_byte_i  (first_byte_i),
    .second_byte_i (second_byte_i),
    .third_byte_i  (third_byte_i),
    .byte_count_i  (byte_count_i),
    .digit_o       (digit),
    .ones_o        (ones),
    .below_o       (below)
  );

  assign in_ready_o = !busy_q;
  assign accept     = in_valid_i && !busy_q;
  assign out_free   = !out_valid_q || out_ready_i;
  assign nonzero    = digit != '0;
  assign write      = nonzero || past_q || zfill_q;

  always_comb begin
    busy_d      = busy_q;
    pc_d        = pc_q;
    past_d      = past_q;
    col_d       = col_q;
    zfill_d     = zfill_q;
    lalign_d    = lalign_q;
    out_valid_d = out_valid_q && !out_ready_i;
    column_d    = column_q;
    char_d      = char_q;
    last_d      = last_q;

    ctl           = '0;
    ctl.place     = word.place;
    ctl.shift     = word.shift;

    if (accept) begin
      ctl.load = 1'b1;
      busy_d   = 1'b1;
      pc_d     = '0;
      past_d   = 1'b0;
      col_d    = '0;
      zfill_d  = leading_zeros_i;
      lalign_d = left_align_i;
    end else if (busy_q) begin
      case (word.op)
        OP_TRIAL: begin
          if (below) begin
            pc_d = word.target;
          end else begin
            ctl.trial = 1'b1;
            pc_d      = pc_q + PcWidth'(1);
          end
        end
        OP_EMIT: begin
          // hold while a write is due and the output register is full
          if (!write || out_free) begin
            if (write) begin
              out_valid_d = 1'b1;
              column_d    = col_q;
              char_d      = CharZero + 7'(digit);
              last_d      = 1'b0;
            end
            past_d        = past_q || nonzero;
            if (zfill_q || !lalign_q || past_q || nonzero) begin
              col_d = col_q + 3'd1;
            end
            ctl.clr_digit = 1'b1;
            pc_d          = pc_q + PcWidth'(1);
          end
        end
        OP_EMIT_LAST: begin
          if (out_free) begin
            out_valid_d = 1'b1;
            column_d    = col_q;
            char_d      = CharZero + 7'(ones);
            last_d      = 1'b1;
            busy_d      = 1'b0;
            pc_d        = word.target;
          end
        end
        default: begin
          busy_d = 1'b0;
          pc_d   = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pc_q        <= '0;
      past_q      <= 1'b0;
      col_q       <= '0;
      zfill_q     <= 1'b0;
      lalign_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      pc_q        <= pc_d;
      past_q      <= past_d;
      col_q       <= col_d;
      zfill_q     <= zfill_d;
      lalign_q    <= lalign_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    column_q <= column_d;
    char_q   <= char_d;
    last_q   <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign column_o    = column_q;
  assign char_code_o = char_q;
  assign last_o      = last_q;

endmodule

>>> design/b2dt_ucode_rom.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2dt_ucode_rom: microprogram store
// One control word per step. Each place runs its trial subtractions from the
// largest shifted power down, then one emit step; a trial jumps straight to
// the emit when the remainder is already below the place power.
// ----------------------------------------------------------------------------
module b2dt_ucode_rom (
  input  logic [b2dt_pkg::PcWidth-1:0] addr_i,
  output b2dt_pkg::ucode_t             word_o
);
  import b2dt_pkg::*;

  always_comb begin
    case (addr_i)
      5'd0:    word_o = uc_trial(PlaceMil, 3'd4, 5'd5);
      5'd1:    word_o = uc_trial(PlaceMil, 3'd3, 5'd5);
      5'd2:    word_o = uc_trial(PlaceMil, 3'd2, 5'd5);
      5'd3:    word_o = uc_trial(PlaceMil, 3'd1, 5'd5);
      5'd4:    word_o = uc_trial(PlaceMil, 3'd0, 5'd5);
      5'd5:    word_o = uc_emit(OP_EMIT);
      5'd6:    word_o = uc_trial(PlaceHk, 3'd3, 5'd10);
      5'd7:    word_o = uc_trial(PlaceHk, 3'd2, 5'd10);
      5'd8:    word_o = uc_trial(PlaceHk, 3'd1, 5'd10);
      5'd9:    word_o = uc_trial(PlaceHk, 3'd0, 5'd10);
      5'd10:   word_o = uc_emit(OP_EMIT);
      5'd11:   word_o = uc_trial(PlaceTk, 3'd3, 5'd15);
      5'd12:   word_o = uc_trial(PlaceTk, 3'd2, 5'd15);
      5'd13:   word_o = uc_trial(PlaceTk, 3'd1, 5'd15);
      5'd14:   word_o = uc_trial(PlaceTk, 3'd0, 5'd15);
      5'd15:   word_o = uc_emit(OP_EMIT);
      5'd16:   word_o = uc_trial(PlaceK, 3'd3, 5'd20);
      5'd17:   word_o = uc_trial(PlaceK, 3'd2, 5'd20);
      5'd18:   word_o = uc_trial(PlaceK, 3'd1, 5'd20);
      5'd19:   word_o = uc_trial(PlaceK, 3'd0, 5'd20);
      5'd20:   word_o = uc_emit(OP_EMIT);
      5'd21:   word_o = uc_trial(PlaceHund, 3'd3, 5'd25);
      5'd22:   word_o = uc_trial(PlaceHund, 3'd2, 5'd25);
      5'd23:   word_o = uc_trial(PlaceHund, 3'd1, 5'd25);
      5'd24:   word_o = uc_trial(PlaceHund, 3'd0, 5'd25);
      5'd25:   word_o = uc_emit(OP_EMIT);
      5'd26:   word_o = uc_trial(PlaceTen, 3'd3, 5'd30);
      5'd27:   word_o = uc_trial(PlaceTen, 3'd2, 5'd30);
      5'd28:   word_o = uc_trial(PlaceTen, 3'd1, 5'd30);
      5'd29:   word_o = uc_trial(PlaceTen, 3'd0, 5'd30);
      5'd30:   word_o = uc_emit(OP_EMIT);
      5'd31:   word_o = uc_emit(OP_EMIT_LAST);
      default: word_o = uc_emit(OP_EMIT_LAST);
    endcase
  end

endmodule

>>> design/b2dt_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2dt_datapath: value register and shared compare-subtract unit
// Loads the assembled value, peels one digit bit per trial step and holds the
// digit of the current place until the emit step clears it.
// ----------------------------------------------------------------------------
module b2dt_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  b2dt_pkg::dp_ctl_t                   ctl_i,
  input  logic [7:0]                          first_byte_i,
  input  logic [7:0]                          second_byte_i,
  input  logic [7:0]                          third_byte_i,
  input  logic [3:0]                          byte_count_i,
  output logic [b2dt_pkg::DigitWidth-1:0]     digit_o,
  output logic [3:0]                          ones_o,
  output logic                                below_o
);
  import b2dt_pkg::*;

  localparam logic [3:0] BytesOne = 4'd1;
  localparam logic [3:0] BytesTwo = 4'd2;

  logic [ValueWidth-1:0] value_q, value_d;
  logic [DigitWidth-1:0] digit_q, digit_d;
  logic [ValueWidth-1:0] load_val;
  logic [ValueWidth-1:0] pw;
  logic [ValueWidth-1:0] trial_val;
  logic                  fits;

  always_comb begin
    case (byte_count_i)
      BytesOne: load_val = {16'd0, first_byte_i};
      BytesTwo: load_val = {8'd0, first_byte_i, second_byte_i};
      default:  load_val = {first_byte_i, second_byte_i, third_byte_i};
    endcase
  end

  assign pw        = place_pow(ctl_i.place);
  assign trial_val = pw << ctl_i.shift;
  assign fits      = value_q >= trial_val;
  assign below_o   = value_q < pw;

  always_comb begin
    value_d = value_q;
    digit_d = digit_q;
    if (ctl_i.load) begin
      value_d = load_val;
      digit_d = '0;
    end else if (ctl_i.trial) begin
      if (fits) begin
        value_d = value_q - trial_val;
        digit_d = digit_q | (DigitWidth'(1) << ctl_i.shift);
      end
    end else if (ctl_i.clr_digit) begin
      digit_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_q <= '0;
    end else begin
      digit_q <= digit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign digit_o = digit_q;
  assign ones_o  = value_q[3:0];

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: regression for binary_to_decimal_text
// Sends 1 to 3 byte numbers with random zero fill and left-align flags over
// the valid/ready input, predicts the column/character writes of each number
// and checks every write, in order and field by field, as it leaves the block.
// The sender runs in random bursts and the receiver stalls in changing
// patterns, including one long hold-off.
// ----------------------------------------------------------------------------
module testbench;
  import b2dt_pkg::*;

  localparam int unsigned RandomNumbers  = 400;
  localparam int unsigned HoldOffCycles  = 300;
  localparam int unsigned WatchdogLimit  = 4000;
  localparam int unsigned DrainCycles    = 80;

  typedef struct packed {
    logic [2:0] column;
    logic [6:0] char_code;
    logic       last;
  } char_write_t;

  typedef enum logic [1:0] {
    RX_STEADY,
    RX_COIN,
    RX_SPARSE,
    RX_PERIODIC
  } rx_mode_e;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [7:0] first_byte_i;
  logic [7:0] second_byte_i;
  logic [7:0] third_byte_i;
  logic [3:0] byte_count_i;
  logic       leading_zeros_i;
  logic       left_align_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [2:0] column_o;
  logic [6:0] char_code_o;
  logic       last_o;

  char_write_t expected_writes[$];
  int unsigned numbers_sent;
  int unsigned writes_checked;
  int unsigned mismatches;
  int unsigned idle_cycles;
  bit          hold_off_req;
  bit          sender_pacing;
  int unsigned burst_left;

  binary_to_decimal_text i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .first_byte_i    (first_byte_i),
    .second_byte_i   (second_byte_i),
    .third_byte_i    (third_byte_i),
    .byte_count_i    (byte_count_i),
    .leading_zeros_i (leading_zeros_i),
    .left_align_i    (left_align_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .column_o        (column_o),
    .char_code_o     (char_code_o),
    .last_o          (last_o)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Queue the character writes one number produces.
  function automatic void predict_writes(input logic [7:0] b0, input logic [7:0] b1,
                                         input logic [7:0] b2, input logic [3:0] cnt,
                                         input logic zfill, input logic lalign);
    logic [23:0] remainder;
    logic [4:0]  digit;
    logic [2:0]  col;
    bit          past_zeros;
    int unsigned weight;
    int          place;
    char_write_t w;
    case (cnt)
      4'd1:    remainder = {16'h0000, b0};
      4'd2:    remainder = {8'h00, b0, b1};
      default: remainder = {b0, b1, b2};
    endcase
    col        = 3'd0;
    past_zeros = 1'b0;
    weight     = 1000000;
    for (place = 0; place < 6; place++) begin
      digit = 5'd0;
      while (remainder >= weight) begin
        remainder = remainder - 24'(weight);
        digit     = digit + 5'd1;
      end
      if (digit != 5'd0 || past_zeros) begin
        past_zeros  = 1'b1;
        w.column    = col;
        w.char_code = CharZero + {2'b00, digit};
        w.last      = 1'b0;
        expected_writes.push_back(w);
      end else if (zfill) begin
        w.column    = col;
        w.char_code = CharZero;
        w.last      = 1'b0;
        expected_writes.push_back(w);
      end
      // hold the column on skipped zeros when left-aligned
      if (zfill || !lalign || past_zeros) col = col + 3'd1;
      weight = weight / 10;
    end
    w.column    = col;
    w.char_code = CharZero + remainder[6:0];
    w.last      = 1'b1;
    expected_writes.push_back(w);
  endfunction

  // Offer one number; returns in the time step of its acceptance or after a gap.
  task automatic send_number(input logic [7:0] b0, input logic [7:0] b1,
                             input logic [7:0] b2, input logic [3:0] cnt,
                             input logic zfill, input logic lalign);
    int unsigned gap;
    in_valid_i      <= 1'b1;
    first_byte_i    <= b0;
    second_byte_i   <= b1;
    third_byte_i    <= b2;
    byte_count_i    <= cnt;
    leading_zeros_i <= zfill;
    left_align_i    <= lalign;
    do @(posedge clk_i); while (!in_ready_o);
    predict_writes(b0, b1, b2, cnt, zfill, lalign);
    numbers_sent++;
    if (sender_pacing) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        gap        = $urandom_range(0, 12);
        if (gap > 0) begin
          in_valid_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic send_random_number();
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [3:0] cnt;
    int unsigned shape;
    b0 = 8'($urandom);
    b1 = 8'($urandom);
    b2 = 8'($urandom);
    case ($urandom_range(0, 3))
      0:       cnt = 4'd1;
      1:       cnt = 4'd2;
      default: cnt = 4'($urandom_range(0, 15));
    endcase
    // bias toward short values so that leading zeros show up often
    shape = $urandom_range(0, 4);
    case (shape)
      1: b0 = 8'h00;
      2: begin
        b0 = 8'h00;
        b1 = 8'h00;
      end
      3: begin
        b0 = 8'h00;
        b1 = 8'h00;
        b2 = 8'($urandom_range(0, 15));
      end
      4: b0 = 8'($urandom_range(8'h98, 8'hFF));
      default: ;
    endcase
    send_number(b0, b1, b2, cnt, 1'($urandom), 1'($urandom));
  endtask

  task automatic test_directed_cases();
    sender_pacing = 1'b0;
    // zero with every flag combination
    send_number(8'h00, 8'h00, 8'h00, 4'd3, 1'b0, 1'b0);
    send_number(8'h00, 8'h00, 8'h00, 4'd3, 1'b1, 1'b0);
    send_number(8'h00, 8'h00, 8'h00, 4'd3, 1'b0, 1'b1);
    send_number(8'h00, 8'h00, 8'h00, 4'd3, 1'b1, 1'b1);
    // largest value, millions count of 16
    send_number(8'hFF, 8'hFF, 8'hFF, 4'd3, 1'b0, 1'b0);
    send_number(8'hFF, 8'hFF, 8'hFF, 4'd3, 1'b1, 1'b0);
    send_number(8'hFF, 8'hFF, 8'hFF, 4'd3, 1'b0, 1'b1);
    send_number(8'hFF, 8'hFF, 8'hFF, 4'd3, 1'b1, 1'b1);
    // either side of the ten million boundary
    send_number(8'h98, 8'h96, 8'h7F, 4'd3, 1'b0, 1'b0);
    send_number(8'h98, 8'h96, 8'h80, 4'd3, 1'b0, 1'b1);
    // short loads with junk in the unused bytes
    send_number(8'hFF, 8'hAA, 8'h55, 4'd1, 1'b0, 1'b0);
    send_number(8'h00, 8'hFF, 8'hFF, 4'd1, 1'b1, 1'b0);
    send_number(8'hFF, 8'hFF, 8'hFF, 4'd2, 1'b0, 1'b1);
    send_number(8'h01, 8'h00, 8'hFF, 4'd2, 1'b0, 1'b1);
    // counts other than 1 or 2 load three bytes; the last two are one-byte loads
    send_number(8'h12, 8'h34, 8'h56, 4'd0, 1'b0, 1'b0);
    send_number(8'h0F, 8'h42, 8'h40, 4'd15, 1'b0, 1'b1);
    send_number(8'h00, 8'h00, 8'h05, 4'd7, 1'b0, 1'b1);
    send_number(8'h00, 8'h27, 8'h10, 4'd4, 1'b0, 1'b1);
    send_number(8'h01, 8'h86, 8'hA0, 4'd8, 1'b1, 1'b1);
    send_number(8'h0A, 8'h00, 8'h00, 4'd1, 1'b0, 1'b1);
    send_number(8'h09, 8'h00, 8'h00, 4'd1, 1'b1, 1'b0);
  endtask

  // Stall the output long enough that the block backs up into its input.
  task automatic test_output_backpressure();
    int i;
    sender_pacing = 1'b0;
    hold_off_req  = 1'b1;
    for (i = 0; i < 30; i++) send_random_number();
  endtask

  // Let every write drain between two groups of numbers.
  task automatic test_drain_pause();
    int i;
    int pass;
    sender_pacing = 1'b1;
    for (pass = 0; pass < 2; pass++) begin
      for (i = 0; i < 12; i++) send_random_number();
      in_valid_i <= 1'b0;
      wait (expected_writes.size() == 0);
      @(posedge clk_i);
    end
  endtask

  task automatic test_random_numbers();
    int i;
    for (i = 0; i < RandomNumbers; i++) begin
      // alternate paced and back-to-back stretches
      if (i % 100 == 0) sender_pacing = (i % 200 == 0);
      send_random_number();
    end
  endtask

  // Output side stall patterns
  initial begin
    rx_mode_e    rx_mode;
    int unsigned rx_mode_left;
    int unsigned rx_phase;
    rx_mode      = RX_STEADY;
    rx_mode_left = 0;
    rx_phase     = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        out_ready_i <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
        hold_off_req = 1'b0;
        out_ready_i <= 1'b1;
      end else begin
        if (rx_mode_left == 0) begin
          rx_mode      = rx_mode_e'($urandom_range(0, 3));
          rx_mode_left = $urandom_range(20, 200);
        end else begin
          rx_mode_left--;
        end
        rx_phase++;
        case (rx_mode)
          RX_STEADY:   out_ready_i <= 1'b1;
          RX_COIN:     out_ready_i <= 1'($urandom);
          RX_SPARSE:   out_ready_i <= ($urandom_range(0, 3) == 0);
          RX_PERIODIC: out_ready_i <= (rx_phase % 5 != 0);
          default:     out_ready_i <= 1'b1;
        endcase
      end
    end
  end

  // Compare each write against the oldest prediction.
  always @(posedge clk_i) begin
    char_write_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      writes_checked++;
      if (expected_writes.size() == 0) begin
        $display("%0t: unexpected write column %0d char 0x%02h last %0b", $time,
                 column_o, char_code_o, last_o);
        mismatches++;
      end else begin
        want = expected_writes.pop_front();
        if (column_o !== want.column) begin
          $display("%0t: column expected %0d actual %0d", $time, want.column, column_o);
          mismatches++;
        end
        if (char_code_o !== want.char_code) begin
          $display("%0t: char_code expected 0x%02h actual 0x%02h", $time,
                   want.char_code, char_code_o);
          mismatches++;
        end
        if (last_o !== want.last) begin
          $display("%0t: last expected %0b actual %0b", $time, want.last, last_o);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < WatchdogLimit) @(posedge clk_i);
    $display("%0t: no transaction for %0d cycles, %0d writes outstanding", $time,
             WatchdogLimit, expected_writes.size());
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    numbers_sent    = 0;
    writes_checked  = 0;
    mismatches      = 0;
    idle_cycles     = 0;
    hold_off_req    = 1'b0;
    sender_pacing   = 1'b0;
    burst_left      = 0;
    rst_ni          <= 1'b0;
    in_valid_i      <= 1'b0;
    first_byte_i    <= 8'h00;
    second_byte_i   <= 8'h00;
    third_byte_i    <= 8'h00;
    byte_count_i    <= 4'd0;
    leading_zeros_i <= 1'b0;
    left_align_i    <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_output_backpressure();
    test_drain_pause();
    test_random_numbers();
    in_valid_i <= 1'b0;
    wait (expected_writes.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
    $display("Formatted %0d numbers (1 to 3 byte loads, zero fill and left-align mixes)",
             numbers_sent);
    $display("Checked %0d character writes, %0d mismatches", writes_checked, mismatches);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
